@@ rtl/dq_pkg.sv @@
// Package for the double-ended queue: sizes, operation and status codes, beat types.
package dq_pkg;

  // Number of cells in the row and width of the occupancy counter
  localparam int unsigned DEPTH   = 64;
  localparam int unsigned CNT_W   = $clog2(DEPTH + 1);
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned ENTRY_W = 7;

  typedef enum logic [1:0] {
    FUNC_PUSH_BACK  = 2'd0,
    FUNC_PUSH_FRONT = 2'd1,
    FUNC_POP_FRONT  = 2'd2,
    FUNC_POP_BACK   = 2'd3
  } func_e_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e_t;

  // Input beat
  typedef struct packed {
    func_e_t                    func;
    logic signed [DATA_W-1:0]   value;
  } in_item_t;

  // Result beat
  typedef struct packed {
    status_e_t                  status;
    logic signed [DATA_W-1:0]   popped_value;
    logic [ENTRY_W-1:0]         entry_count;
  } out_item_t;

  // Shift controls broadcast to every cell
  typedef struct packed {
    logic shift_right;  // push front: take the left neighbour
    logic shift_left;   // pop front: take the right neighbour
  } cell_ctrl_t;

endpackage

@@ rtl/dq_cell.sv @@
// One storage cell of the queue row, loading from either neighbour or the pushed value.
module dq_cell (
  input  logic                              clk,
  input  dq_pkg::cell_ctrl_t                ctrl,
  input  logic                              load,
  input  logic signed [dq_pkg::DATA_W-1:0]  value,
  input  logic signed [dq_pkg::DATA_W-1:0]  left_data,
  input  logic signed [dq_pkg::DATA_W-1:0]  right_data,
  output logic signed [dq_pkg::DATA_W-1:0]  data_q
);
  import dq_pkg::*;

  logic signed [DATA_W-1:0] data_r;
  logic signed [DATA_W-1:0] data_nxt;

  // Next value: push-back load wins, else shift, else hold
  always_comb begin
    data_nxt = data_r;
    if (load) begin
      data_nxt = value;
    end else if (ctrl.shift_right) begin
      data_nxt = left_data;
    end else if (ctrl.shift_left) begin
      data_nxt = right_data;
    end
  end

  // Payload only, no reset
  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data_q = data_r;

endmodule

@@ rtl/double_ended_queue_core.sv @@
// Double-ended queue built as a row of shifting cells with the front held in cell zero.
// Latency: the result beat appears on the cycle after the command is taken.
// Throughput: one command per cycle; busy is tied low and never stalls a command.
// Reset (rst_n low, synchronous) empties the queue and drops any pending result;
// cell contents are left as they are and never read before being written.
// Results are shown for one cycle under out_strobe; the receiver cannot stall.
module double_ended_queue_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  dq_pkg::in_item_t  in_item,
  output logic              out_strobe,
  output dq_pkg::out_item_t out_item
);
  import dq_pkg::*;

  logic [CNT_W-1:0]         count_r;
  logic [CNT_W-1:0]         count_nxt;
  logic                     out_strobe_r;
  out_item_t                out_item_r;
  out_item_t                out_item_nxt;
  cell_ctrl_t               ctrl;
  logic                     accept;
  logic                     full;
  logic                     empty;
  logic                     push_back_ok;
  logic signed [DATA_W-1:0] cell_q [DEPTH];
  logic [DEPTH-1:0]         cell_load;

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign full   = (count_r == CNT_W'(DEPTH));
  assign empty  = (count_r == '0);

  // Command decode and result formation
  always_comb begin
    ctrl         = '0;
    push_back_ok = 1'b0;
    count_nxt    = count_r;
    out_item_nxt.status       = ST_DONE;
    out_item_nxt.popped_value = '0;
    case (in_item.func)
      FUNC_PUSH_BACK: begin
        if (full) begin
          out_item_nxt.status = ST_FULL;
        end else begin
          push_back_ok = accept;
          count_nxt    = count_r + 1'b1;
        end
      end
      FUNC_PUSH_FRONT: begin
        if (full) begin
          out_item_nxt.status = ST_FULL;
        end else begin
          ctrl.shift_right = accept;
          count_nxt        = count_r + 1'b1;
        end
      end
      FUNC_POP_FRONT: begin
        if (empty) begin
          out_item_nxt.status = ST_EMPTY;
        end else begin
          ctrl.shift_left           = accept;
          out_item_nxt.popped_value = cell_q[0];
          count_nxt                 = count_r - 1'b1;
        end
      end
      default: begin
        // pop back: the back cell simply drops out of the window
        if (empty) begin
          out_item_nxt.status = ST_EMPTY;
        end else begin
          count_nxt = count_r - 1'b1;
        end
      end
    endcase
    out_item_nxt.entry_count = ENTRY_W'(count_nxt);
  end

  // Row of cells; cell zero takes the pushed value on a front push
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [DATA_W-1:0] left_d;
    logic signed [DATA_W-1:0] right_d;

    if (i == 0) begin : g_first
      assign left_d = in_item.value;
    end else begin : g_mid
      assign left_d = cell_q[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_d = '0;
    end else begin : g_inner
      assign right_d = cell_q[i+1];
    end

    // back push lands in the first free cell
    assign cell_load[i] = push_back_ok && (count_r == CNT_W'(i));

    dq_cell u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .load       (cell_load[i]),
      .value      (in_item.value),
      .left_data  (left_d),
      .right_data (right_d),
      .data_q     (cell_q[i])
    );
  end

  // Occupancy and result strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r      <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= accept;
      if (accept) begin
        count_r <= count_nxt;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      out_item_r <= out_item_nxt;
    end
  end

  assign out_strobe = out_strobe_r;
  assign out_item   = out_item_r;

endmodule

@@ tb/sv/tb_double_ended_queue_core.sv @@
// Self-checking testbench for the double-ended queue core: directed and random command beats.
module tb_double_ended_queue_core;
  timeunit 1ns;
  timeprecision 1ps;

  import dq_pkg::*;

  logic      clk;
  logic      rst_n;
  logic      start;
  logic      busy;
  in_item_t  in_item;
  logic      out_strobe;
  out_item_t out_item;

  double_ended_queue_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_strobe(out_strobe),
    .out_item  (out_item)
  );

  // 2 ns clock
  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // Commands waiting to be driven, results the deque should still return
  in_item_t  cmd_queue[$];
  out_item_t due_results[$];
  int        drain_points[$];   // command index before which the sender waits for all results
  int        issued;
  int        fail_count;
  bit        took;              // set on the edge that accepts the current beat
  int        burst_left;
  int        gap_left;
  out_item_t want;

  // Shadow copy of the deque
  logic signed [DATA_W-1:0] shadow_ring [DEPTH];
  logic [5:0]               shadow_front;
  int unsigned              shadow_occ;

  // Apply one command to the shadow deque and return the result it should give
  function automatic out_item_t deque_apply(in_item_t cmd);
    out_item_t res;
    res.status       = ST_DONE;
    res.popped_value = '0;
    case (cmd.func)
      FUNC_PUSH_BACK: begin
        if (shadow_occ >= DEPTH) begin
          res.status = ST_FULL;
        end else begin
          shadow_ring[(shadow_front + shadow_occ) % DEPTH] = cmd.value;
          shadow_occ++;
        end
      end
      FUNC_PUSH_FRONT: begin
        if (shadow_occ >= DEPTH) begin
          res.status = ST_FULL;
        end else begin
          shadow_front = shadow_front - 6'd1;
          shadow_ring[shadow_front] = cmd.value;
          shadow_occ++;
        end
      end
      FUNC_POP_FRONT: begin
        if (shadow_occ == 0) begin
          res.status = ST_EMPTY;
        end else begin
          res.popped_value = shadow_ring[shadow_front];
          shadow_front = shadow_front + 6'd1;
          shadow_occ--;
        end
      end
      default: begin
        // pop back: status only
        if (shadow_occ == 0) begin
          res.status = ST_EMPTY;
        end else begin
          shadow_occ--;
        end
      end
    endcase
    res.entry_count = shadow_occ[ENTRY_W-1:0];
    return res;
  endfunction

  function automatic in_item_t make_cmd(func_e_t f, logic [DATA_W-1:0] v);
    in_item_t cmd;
    cmd.func  = f;
    cmd.value = v;
    return cmd;
  endfunction

  // Values lean towards the extremes now and then
  function automatic logic [DATA_W-1:0] rand_word();
    case ($urandom_range(0, 9))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return 32'h0000_0000;
      3:       return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  // One random command, pushes chosen with the given percentage
  task automatic add_random(int push_pct);
    if ($urandom_range(1, 100) <= push_pct)
      cmd_queue.push_back(make_cmd($urandom_range(0, 1) ? FUNC_PUSH_FRONT : FUNC_PUSH_BACK,
                                   rand_word()));
    else
      cmd_queue.push_back(make_cmd($urandom_range(0, 1) ? FUNC_POP_BACK : FUNC_POP_FRONT,
                                   rand_word()));
  endtask

  task automatic check_field(string name, logic [DATA_W-1:0] exp, logic [DATA_W-1:0] got);
    if (exp !== got) begin
      $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, exp, got);
      fail_count++;
    end
  endtask

  // Monitor: predict on acceptance, check each result beat against the oldest expectation
  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) begin
        due_results.push_back(deque_apply(in_item));
        took = 1'b1;
      end
      if (out_strobe) begin
        if (due_results.size() == 0) begin
          $display("%0t ns: unexpected result beat, expected none, actual %p", $time, out_item);
          fail_count++;
        end else begin
          want = due_results.pop_front();
          check_field("status", want.status, out_item.status);
          check_field("popped_value", want.popped_value, out_item.popped_value);
          check_field("entry_count", want.entry_count, out_item.entry_count);
        end
      end
    end
  end

  // Driver: bursts of beats with random gaps, holding a beat until busy is low
  always @(negedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
      took = 1'b0;
    end else if (start && !took) begin
      // beat not yet taken, keep it on the port
    end else begin
      took = 1'b0;
      if (drain_points.size() != 0 && drain_points[0] <= issued && due_results.size() != 0) begin
        start <= 1'b0;
      end else if (gap_left > 0) begin
        gap_left--;
        start <= 1'b0;
      end else if (cmd_queue.size() == 0) begin
        start <= 1'b0;
      end else begin
        while (drain_points.size() != 0 && drain_points[0] <= issued)
          void'(drain_points.pop_front());
        in_item <= cmd_queue.pop_front();
        start   <= 1'b1;
        issued++;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 30);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end
      end
    end
  end

  // Stimulus, reset and end of run
  initial begin
    int seg_len;
    int push_pct;
    rst_n        = 1'b0;
    start        = 1'b0;
    in_item      = '0;
    took         = 1'b0;
    issued       = 0;
    fail_count   = 0;
    burst_left   = 0;
    gap_left     = 0;
    shadow_front = '0;
    shadow_occ   = 0;

    // Directed: pops on empty, extreme values at both ends, both pop kinds
    cmd_queue.push_back(make_cmd(FUNC_POP_FRONT, 32'h1234_5678));
    cmd_queue.push_back(make_cmd(FUNC_POP_BACK, 32'hffff_ffff));
    cmd_queue.push_back(make_cmd(FUNC_PUSH_BACK, 32'h7fff_ffff));
    cmd_queue.push_back(make_cmd(FUNC_PUSH_FRONT, 32'h8000_0000));
    cmd_queue.push_back(make_cmd(FUNC_PUSH_BACK, 32'h0000_0000));
    cmd_queue.push_back(make_cmd(FUNC_PUSH_FRONT, 32'hffff_ffff));
    cmd_queue.push_back(make_cmd(FUNC_POP_FRONT, 32'h0));
    cmd_queue.push_back(make_cmd(FUNC_POP_BACK, 32'h0));
    cmd_queue.push_back(make_cmd(FUNC_POP_FRONT, 32'h0));
    cmd_queue.push_back(make_cmd(FUNC_POP_FRONT, 32'h0));
    cmd_queue.push_back(make_cmd(FUNC_POP_BACK, 32'h0));
    cmd_queue.push_back(make_cmd(FUNC_POP_FRONT, 32'h0));
    cmd_queue.push_back(make_cmd(FUNC_PUSH_FRONT, 32'ha5a5_a5a5));
    cmd_queue.push_back(make_cmd(FUNC_POP_BACK, 32'h5a5a_5a5a));
    cmd_queue.push_back(make_cmd(FUNC_PUSH_BACK, 32'h5a5a_5a5a));
    cmd_queue.push_back(make_cmd(FUNC_POP_FRONT, 32'ha5a5_a5a5));
    cmd_queue.push_back(make_cmd(FUNC_PUSH_FRONT, 32'h0000_0001));
    cmd_queue.push_back(make_cmd(FUNC_POP_FRONT, 32'h0));
    drain_points.push_back(cmd_queue.size());

    // Fill to the brim, push past full at both ends, then empty it from both ends
    for (int i = 0; i < DEPTH; i++)
      add_random(100);
    cmd_queue.push_back(make_cmd(FUNC_PUSH_BACK, rand_word()));
    cmd_queue.push_back(make_cmd(FUNC_PUSH_FRONT, rand_word()));
    for (int i = 0; i < DEPTH + 2; i++)
      add_random(0);
    drain_points.push_back(cmd_queue.size());

    // Random segments: balanced, filling and draining, so full and empty both recur
    while (cmd_queue.size() < 2000) begin
      seg_len = $urandom_range(20, 120);
      case ($urandom_range(0, 2))
        0:       push_pct = 50;
        1:       push_pct = 85;
        default: push_pct = 15;
      endcase
      for (int i = 0; i < seg_len; i++)
        add_random(push_pct);
      if ($urandom_range(0, 5) == 0)
        drain_points.push_back(cmd_queue.size());
    end

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (cmd_queue.size() != 0 || start || due_results.size() != 0)
      @(negedge clk);
    repeat (4) @(negedge clk);

    if (fail_count == 0)
      $display("double_ended_queue_core test passed");
    else
      $display("double_ended_queue_core test failed");
    $finish;
  end

  // Watchdog
  initial begin
    #500000;
    $display("double_ended_queue_core test failed");
    $finish;
  end

endmodule

@@ double_ended_queue_core.f @@
rtl/dq_pkg.sv
rtl/dq_cell.sv
rtl/double_ended_queue_core.sv
tb/sv/tb_double_ended_queue_core.sv
